[src/ltstep_pkg.sv]
`default_nettype none

package ltstep_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] SURVIVE_MIN = 4'd2;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_DO,
      ST_GEN_LAST,
      ST_GEN_FIRST,
      ST_GEN_LOAD,
      ST_GEN_RUN,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      RD_REQ,
      RD_LAST,
      RD_FIRST,
      RD_NEXT1,
      RD_NEXT2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_ZERO,
      WR_CELL,
      WR_GEN
   } wr_sel_type;

   typedef struct packed {
      logic       req_load;
      logic       ctr_clr;
      logic       ctr_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       prev_load;
      logic       first_load;
      logic       win_shift;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic   ctr_last_clear;
      logic   ctr_last_gen;
      logic   oor;
      op_type op;
      logic   rsp_free;
   } sts_type;

endpackage

`default_nettype wire

[src/ltstep_ctrl.sv]
`default_nettype none

module ltstep_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_operation,
   output logic                     req_stall,
   output ltstep_pkg::cmd_type      cmd,
   input  wire ltstep_pkg::sts_type sts
);
   import ltstep_pkg::*;

   state_type state_ff, state_in;
   op_type    new_op;

   assign new_op = op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.rd_sel = RD_REQ;
      cmd.wr_sel = WR_ZERO;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_ZERO;
            cmd.ctr_inc = 1'b1;
            if (sts.ctr_last_clear) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               cmd.ctr_clr  = 1'b1;
               unique case (new_op)
                  OP_WRITE, OP_READ: state_in = ST_ACC_RD;
                  OP_STEP:           state_in = ST_GEN_LAST;
                  OP_CLEAR:          state_in = ST_CLEAR;
               endcase
            end
         end
         ST_ACC_RD: begin
            cmd.rd_en  = !sts.oor;
            cmd.rd_sel = RD_REQ;
            state_in   = ST_ACC_DO;
         end
         ST_ACC_DO: begin
            cmd.wr_en  = (sts.op == OP_WRITE) && !sts.oor;
            cmd.wr_sel = WR_CELL;
            state_in   = ST_DONE;
         end
         ST_GEN_LAST: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
            state_in   = ST_GEN_FIRST;
         end
         ST_GEN_FIRST: begin
            cmd.prev_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_FIRST;
            state_in      = ST_GEN_LOAD;
         end
         ST_GEN_LOAD: begin
            cmd.first_load = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_NEXT1;
            state_in       = ST_GEN_RUN;
         end
         ST_GEN_RUN: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_GEN;
            cmd.win_shift = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_NEXT2;
            cmd.ctr_inc   = 1'b1;
            if (sts.ctr_last_gen) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/ltstep_dp.sv]
`default_nettype none

module ltstep_dp #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128,
   parameter int NRW      = $clog2(MAX_ROWS + 1),
   parameter int NCW      = $clog2(MAX_COLS + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [NRW-1:0]      num_rows,
   input  wire logic [NCW-1:0]      num_cols,
   input  wire logic [1:0]          req_operation,
   input  wire logic [6:0]          req_row_index,
   input  wire logic [6:0]          req_col_index,
   input  wire logic                req_cell_value_in,
   input  wire ltstep_pkg::cmd_type cmd,
   output ltstep_pkg::sts_type      sts,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_cell_value_out,
   output logic                     rsp_index_out_of_range
);
   import ltstep_pkg::*;

   localparam int RAW = $clog2(MAX_ROWS);
   localparam int CAW = $clog2(MAX_COLS);

   // row-wide grid storage
   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rdata_ff;

   op_type              op_ff;
   logic [6:0]          row_ff, col_ff;
   logic                val_ff, oor_ff, oor_in;
   logic [RAW-1:0]      ctr_ff;
   logic [MAX_COLS-1:0] prev_ff, cur_ff, first_ff, nxt_row;
   logic                rsp_valid_ff, rsp_value_ff, rsp_oor_ff;

   logic [RAW-1:0]      rd_addr, wr_addr;
   logic [RAW:0]        ahead;
   logic                rd_go;
   logic [MAX_COLS-1:0] wr_data, cell_row, gen_row;
   logic [RAW-1:0]      last_row;
   logic [CAW-1:0]      last_col;
   logic [NRW-1:0]      nr_m1;
   logic [NCW-1:0]      nc_m1;

   assign nr_m1    = num_rows - NRW'(1);
   assign nc_m1    = num_cols - NCW'(1);
   assign last_row = RAW'(nr_m1);
   assign last_col = CAW'(nc_m1);

   assign oor_in = ((op_type'(req_operation) == OP_WRITE) ||
                    (op_type'(req_operation) == OP_READ)) &&
                   ((32'(req_row_index) >= 32'(num_rows)) ||
                    (32'(req_col_index) >= 32'(num_cols)));

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff  <= op_type'(req_operation);
         row_ff <= req_row_index;
         col_ff <= req_col_index;
         val_ff <= req_cell_value_in;
         oor_ff <= oor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.ctr_clr) begin
         ctr_ff <= '0;
      end else if (cmd.ctr_inc) begin
         ctr_ff <= ctr_ff + RAW'(1);
      end
   end

   // read address select; look-ahead reads past the last active row are dropped
   always_comb begin
      ahead = {1'b0, ctr_ff} + (RAW+1)'(1);
      rd_go = cmd.rd_en;
      unique case (cmd.rd_sel)
         RD_REQ:   rd_addr = RAW'(row_ff);
         RD_LAST:  rd_addr = last_row;
         RD_FIRST: rd_addr = '0;
         RD_NEXT1: rd_addr = RAW'(ahead);
         RD_NEXT2: begin
            ahead   = {1'b0, ctr_ff} + (RAW+1)'(2);
            rd_addr = RAW'(ahead);
         end
         default:  rd_addr = '0;
      endcase
      if ((cmd.rd_sel == RD_NEXT1) || (cmd.rd_sel == RD_NEXT2)) begin
         rd_go = cmd.rd_en && (32'(ahead) < 32'(num_rows));
      end
   end

   always_comb begin
      cell_row                 = rdata_ff;
      cell_row[CAW'(col_ff)]   = val_ff;
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_ZERO: begin
            wr_addr = ctr_ff;
            wr_data = '0;
         end
         WR_CELL: begin
            wr_addr = RAW'(row_ff);
            wr_data = cell_row;
         end
         WR_GEN: begin
            wr_addr = ctr_ff;
            wr_data = gen_row;
         end
         default: begin
            wr_addr = ctr_ff;
            wr_data = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_go) begin
         rdata_ff <= grid_mem[rd_addr];
      end
   end

   // three-row window; the bottom row wraps to the saved copy of row 0
   assign nxt_row = (ctr_ff == last_row) ? first_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.prev_load) begin
         prev_ff <= rdata_ff;
      end
      if (cmd.first_load) begin
         cur_ff   <= rdata_ff;
         first_ff <= rdata_ff;
      end
      if (cmd.win_shift) begin
         prev_ff <= cur_ff;
         cur_ff  <= nxt_row;
      end
   end

   // one lane per column
   logic [MAX_COLS-1:0] p_l, p_r, c_l, c_r, n_l, n_r;
   logic [3:0]          nbr;

   always_comb begin
      p_l = '0; p_r = '0; c_l = '0; c_r = '0; n_l = '0; n_r = '0;
      nbr = '0;
      gen_row = cur_ff;
      for (int j = 1; j < MAX_COLS; j++) begin
         p_l[j] = prev_ff[j-1];
         c_l[j] = cur_ff[j-1];
         n_l[j] = nxt_row[j-1];
      end
      for (int j = 0; j < MAX_COLS - 1; j++) begin
         p_r[j] = prev_ff[j+1];
         c_r[j] = cur_ff[j+1];
         n_r[j] = nxt_row[j+1];
      end
      p_l[0] = prev_ff[last_col];
      c_l[0] = cur_ff[last_col];
      n_l[0] = nxt_row[last_col];
      p_r[last_col] = prev_ff[0];
      c_r[last_col] = cur_ff[0];
      n_r[last_col] = nxt_row[0];
      for (int j = 0; j < MAX_COLS; j++) begin
         nbr = 4'(p_l[j]) + 4'(prev_ff[j]) + 4'(p_r[j]) + 4'(c_l[j]) + 4'(c_r[j]) +
               4'(n_l[j]) + 4'(nxt_row[j]) + 4'(n_r[j]);
         if (32'(j) < 32'(num_cols)) begin
            if (cur_ff[j]) begin
               gen_row[j] = (nbr >= SURVIVE_MIN) && (nbr <= BIRTH_COUNT);
            end else begin
               gen_row[j] = (nbr == BIRTH_COUNT);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_value_ff <= (op_ff == OP_READ) && !oor_ff && rdata_ff[CAW'(col_ff)];
         rsp_oor_ff   <= oor_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_cell_value_out     = rsp_value_ff;
   assign rsp_index_out_of_range = rsp_oor_ff;

   assign sts.ctr_last_clear = (ctr_ff == RAW'(MAX_ROWS - 1));
   assign sts.ctr_last_gen   = (ctr_ff == last_row);
   assign sts.oor            = oor_ff;
   assign sts.op             = op_ff;
   assign sts.rsp_free       = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

[src/life_automaton_toroidal_step_top.sv]
// Toroidal life grid engine, one command per request, one request at a time.
// Cell read/write: row read, then modify-write, then respond.
// Advance one generation: every active row is rewritten (rows_in_use clamped to 1..MAX_ROWS);
// one grid row is updated per cycle.
// Clear: all MAX_ROWS rows zeroed, one row zeroed per cycle in the grid memory.
// After reset the same row sweep clears the grid before req is taken.
`default_nettype none

module life_automaton_toroidal_step_top #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [6:0] req_row_index,
   input  wire logic [6:0] req_col_index,
   input  wire logic       req_cell_value_in,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_cell_value_out,
   output logic            rsp_index_out_of_range,
   // register writes
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);
   import ltstep_pkg::*;

   localparam int NRW = $clog2(MAX_ROWS + 1);
   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam int ERW = NRW + 8;
   localparam int ECW = NCW + 8;

   logic [7:0]     rows_ff, cols_ff;
   logic [ERW-1:0] rows_ext;
   logic [ECW-1:0] cols_ext;
   logic [NRW-1:0] num_rows;
   logic [NCW-1:0] num_cols;
   cmd_type        cmd;
   sts_type        sts;

   // registers always take a write
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 8'd128;
         cols_ff <= 8'd128;
      end else if (csr_valid) begin
         if (csr_index == CSR_ROWS) begin
            rows_ff <= csr_wdata;
         end else begin
            cols_ff <= csr_wdata;
         end
      end
   end

   // zero acts as one, anything past the grid acts as the grid size
   assign rows_ext = ERW'(rows_ff);
   assign cols_ext = ECW'(cols_ff);

   always_comb begin
      priority if (rows_ext == '0) begin
         num_rows = NRW'(1);
      end else if (rows_ext > ERW'(MAX_ROWS)) begin
         num_rows = NRW'(MAX_ROWS);
      end else begin
         num_rows = NRW'(rows_ext);
      end
      priority if (cols_ext == '0) begin
         num_cols = NCW'(1);
      end else if (cols_ext > ECW'(MAX_COLS)) begin
         num_cols = NCW'(MAX_COLS);
      end else begin
         num_cols = NCW'(cols_ext);
      end
   end

   ltstep_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   ltstep_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .NRW      (NRW),
      .NCW      (NCW)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .num_rows               (num_rows),
      .num_cols               (num_cols),
      .req_operation          (req_operation),
      .req_row_index          (req_row_index),
      .req_col_index          (req_col_index),
      .req_cell_value_in      (req_cell_value_in),
      .cmd                    (cmd),
      .sts                    (sts),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_cell_value_out     (rsp_cell_value_out),
      .rsp_index_out_of_range (rsp_index_out_of_range)
   );

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import ltstep_pkg::*;

   localparam int N_ROWS = 128;
   localparam int N_COLS = 128;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct packed {
      op_type     op;
      logic [6:0] row;
      logic [6:0] col;
      logic       value;
   } life_cmd_t;

   typedef struct packed {
      logic cell_out;
      logic oor;
   } life_rsp_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = '0;
   logic [6:0] req_row_index = '0;
   logic [6:0] req_col_index = '0;
   logic       req_cell_value_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_cell_value_out;
   logic       rsp_index_out_of_range;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   life_automaton_toroidal_step_top uut (.*);

   always #5 clock = ~clock;

   // predictor state: shadow grid and active dimensions
   logic       grid_model [N_ROWS][N_COLS];
   logic [7:0] rows_reg = 8'd128;
   logic [7:0] cols_reg = 8'd128;

   life_cmd_t  cmd_queue[$];
   life_rsp_t  rsp_expected[$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   bit   hold_off_recv = 1'b0;
   int   hold_off_left = 0;
   int   errors = 0;
   int   quiet_cycles = 0;

   function automatic int active_dim(logic [7:0] v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // one generation over the active torus; each wrapped neighbor counts separately
   function automatic void life_generation();
      int  nr, nc, sum, r, c;
      logic nxt [N_ROWS][N_COLS];
      nr = active_dim(rows_reg, N_ROWS);
      nc = active_dim(cols_reg, N_COLS);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            sum = 0;
            for (int dr = 0; dr < 3; dr++) begin
               for (int dc = 0; dc < 3; dc++) begin
                  if (dr == 1 && dc == 1) continue;
                  r = (i + nr + dr - 1) % nr;
                  c = (j + nc + dc - 1) % nc;
                  sum += grid_model[r][c];
               end
            end
            if (grid_model[i][j]) nxt[i][j] = (sum == 2 || sum == 3);
            else nxt[i][j] = (sum == 3);
         end
      end
      for (int i = 0; i < nr; i++)
         for (int j = 0; j < nc; j++)
            grid_model[i][j] = nxt[i][j];
   endfunction

   function automatic life_rsp_t life_predict(life_cmd_t cmd);
      life_rsp_t res;
      int nr, nc;
      res = '0;
      nr = active_dim(rows_reg, N_ROWS);
      nc = active_dim(cols_reg, N_COLS);
      case (cmd.op)
         OP_WRITE, OP_READ: begin
            if (cmd.row >= nr || cmd.col >= nc) res.oor = 1'b1;
            else if (cmd.op == OP_WRITE) grid_model[cmd.row][cmd.col] = cmd.value;
            else res.cell_out = grid_model[cmd.row][cmd.col];
         end
         OP_STEP: life_generation();
         default: begin
            for (int i = 0; i < N_ROWS; i++)
               for (int j = 0; j < N_COLS; j++)
                  grid_model[i][j] = 1'b0;
         end
      endcase
      return res;
   endfunction

   // driver: valid stays up until accept, with random idle gaps; payload only changes after accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) rsp_expected.push_back(life_predict(cmd_queue.pop_front()));
         if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            life_cmd_t nxt;
            nxt = cmd_queue[0];
            req_valid <= 1'b1;
            req_operation <= nxt.op;
            req_row_index <= nxt.row;
            req_col_index <= nxt.col;
            req_cell_value_in <= nxt.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor plus receiver stall generation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected.size() == 0) begin
               $display("%0t: response with nothing expected: cell=%0b oor=%0b", $time,
                        rsp_cell_value_out, rsp_index_out_of_range);
               errors++;
            end else begin
               life_rsp_t exp_rsp;
               exp_rsp = rsp_expected.pop_front();
               if (exp_rsp.cell_out !== rsp_cell_value_out) begin
                  $display("%0t: cell_value_out expected %0b got %0b", $time,
                           exp_rsp.cell_out, rsp_cell_value_out);
                  errors++;
               end
               if (exp_rsp.oor !== rsp_index_out_of_range) begin
                  $display("%0t: index_out_of_range expected %0b got %0b", $time,
                           exp_rsp.oor, rsp_index_out_of_range);
                  errors++;
               end
            end
         end
         if (hold_off_recv) begin
            hold_off_left <= 300;
            rsp_stall <= 1'b1;
         end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (cmd_queue.size() != 0 || req_valid || rsp_expected.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ROWS) rows_reg = data;
      else cols_reg = data;
      @(posedge clock);
   endtask

   function automatic void push_cmd(op_type op, int r, int c, int v);
      life_cmd_t cmd;
      cmd.op = op;
      cmd.row = 7'(r);
      cmd.col = 7'(c);
      cmd.value = 1'(v);
      cmd_queue.push_back(cmd);
   endfunction

   // random phase: accesses around the active range with occasional steps and clears
   task automatic random_phase(int count, int nr, int nc);
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            push_cmd(OP_WRITE, $urandom_range(nr), $urandom_range(nc), $urandom_range(1));
         else if (pick < 75)
            push_cmd(OP_READ, $urandom_range(nr), $urandom_range(nc), $urandom_range(1));
         else if (pick < 85)
            push_cmd(OP_WRITE, $urandom_range(127), $urandom_range(127), $urandom_range(1));
         else if (pick < 97)
            push_cmd(OP_STEP, $urandom_range(127), $urandom_range(127), $urandom_range(1));
         else
            push_cmd(OP_CLEAR, $urandom_range(127), $urandom_range(127), $urandom_range(1));
      end
   endtask

   initial begin
      int nr, nc;
      for (int i = 0; i < N_ROWS; i++)
         for (int j = 0; j < N_COLS; j++)
            grid_model[i][j] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: full-size corners, three live cells across the corner wrap, clear
      push_cmd(OP_WRITE, 127, 127, 1);
      push_cmd(OP_READ, 127, 127, 0);
      push_cmd(OP_WRITE, 0, 0, 1);
      push_cmd(OP_WRITE, 0, 127, 1);
      push_cmd(OP_STEP, 0, 0, 0);
      push_cmd(OP_READ, 0, 0, 0);
      push_cmd(OP_READ, 127, 0, 0);
      push_cmd(OP_READ, 1, 0, 1);
      push_cmd(OP_CLEAR, 0, 0, 0);
      push_cmd(OP_READ, 127, 127, 0);
      wait_drained();

      // zero acts as one: single cell wraps onto itself
      csr_write(CSR_ROWS, 8'd0);
      csr_write(CSR_COLS, 8'd0);
      push_cmd(OP_WRITE, 0, 0, 1);
      push_cmd(OP_WRITE, 0, 1, 1);
      push_cmd(OP_READ, 1, 0, 0);
      push_cmd(OP_STEP, 0, 0, 0);
      push_cmd(OP_READ, 0, 0, 0);
      wait_drained();

      // above max clamps; two-wide torus
      csr_write(CSR_ROWS, 8'd255);
      csr_write(CSR_COLS, 8'd2);
      push_cmd(OP_WRITE, 100, 1, 1);
      push_cmd(OP_WRITE, 101, 1, 1);
      push_cmd(OP_WRITE, 5, 2, 1);
      push_cmd(OP_STEP, 0, 0, 0);
      push_cmd(OP_READ, 100, 0, 0);
      push_cmd(OP_READ, 101, 1, 0);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      csr_write(CSR_ROWS, 8'd6);
      csr_write(CSR_COLS, 8'd6);
      hold_off_recv = 1'b1;
      wait (hold_off_left > 0);
      hold_off_recv = 1'b0;
      random_phase(10, 7, 7);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 55 : 0;
         recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 37 : 0;
         nr = $urandom_range(3, 12);
         nc = (ph == 2) ? 128 : $urandom_range(1, 12);
         csr_write(CSR_ROWS, 8'(nr));
         csr_write(CSR_COLS, 8'(nc));
         random_phase(30, nr, nc > 127 ? 127 : nc);
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
